[hdl/mkcd_pkg.sv]
// ----------------------------------------------------------------------------
// mkcd_pkg
// shared constants and types of the multi-key click event detector
// ----------------------------------------------------------------------------
package mkcd_pkg;

    localparam int NUM_KEYS = 5;
    localparam int PIN_BITS = 5;
    localparam int EV_BITS  = 7;
    localparam int KIDX_W   = 3;

    localparam logic [EV_BITS-1:0] EV_HOLD   = 7'h01;
    localparam logic [EV_BITS-1:0] EV_DOWN   = 7'h02;
    localparam logic [EV_BITS-1:0] EV_UP     = 7'h04;
    localparam logic [EV_BITS-1:0] EV_SINGLE = 7'h08;
    localparam logic [EV_BITS-1:0] EV_DOUBLE = 7'h10;
    localparam logic [EV_BITS-1:0] EV_LONG   = 7'h20;
    localparam logic [EV_BITS-1:0] EV_REPEAT = 7'h40;

    localparam logic [1:0] REG_SCAN_PERIOD   = 2'd0;
    localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd1;
    localparam logic [1:0] REG_LONG_TIME     = 2'd2;
    localparam logic [1:0] REG_REPEAT_TIME   = 2'd3;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    typedef logic [EV_BITS-1:0] ev_flags_t;

    typedef struct packed {
        logic [7:0]  scan_period;
        logic [15:0] double_window;
        logic [15:0] long_time;
        logic [15:0] repeat_time;
    } cfg_t;

    typedef struct packed {
        logic      tick;
        logic      scan;
        logic      pressed;
        logic      clear;
        ev_flags_t mask;
    } lane_ctrl_t;

endpackage

[hdl/multi_key_click_event_detector.sv]
// ----------------------------------------------------------------------------
// multi_key_click_event_detector
// per-key click, double, long and repeat detection with sticky event flags
// ----------------------------------------------------------------------------
// the result item is registered in the cycle after its input item is accepted
// throughput: one item per cycle, one lane per key updates in parallel
// the single output register stalls input only while its item is not taken
// reset: flags, timers, click machines and divider clear at once, registers
// return to scan_period 20, double_window 200, long_time 2000, repeat_time 100
module multi_key_click_event_detector
    import mkcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pin_levels[4:0], key_index[7:5], event_mask[14:8], 0
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // hit[0], flags_seen[7:1]
);

    cfg_t       cfg_reg, cfg_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] div_inc;
    logic       in_fire;
    logic       tick;
    logic       scan;
    logic       cfg_we;
    logic [PIN_BITS-1:0] pin_levels;
    logic [KIDX_W-1:0]   key_index;
    ev_flags_t  event_mask;
    logic [NUM_KEYS-1:0][EV_BITS-1:0] lane_flags;
    logic [NUM_KEYS-1:0] lane_clear;
    logic       out_hit;
    ev_flags_t  out_flags;

    assign pin_levels = s_tdata[4:0];
    assign key_index  = s_tdata[7:5];
    assign event_mask = s_tdata[14:8];

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (paddr[3:2])
                REG_SCAN_PERIOD:   cfg_next.scan_period   = pwdata[7:0];
                REG_DOUBLE_WINDOW: cfg_next.double_window = pwdata[15:0];
                REG_LONG_TIME:     cfg_next.long_time     = pwdata[15:0];
                REG_REPEAT_TIME:   cfg_next.repeat_time   = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
        case (paddr[3:2])
            REG_SCAN_PERIOD:   prdata = {24'd0, cfg_reg.scan_period};
            REG_DOUBLE_WINDOW: prdata = {16'd0, cfg_reg.double_window};
            REG_LONG_TIME:     prdata = {16'd0, cfg_reg.long_time};
            REG_REPEAT_TIME:   prdata = {16'd0, cfg_reg.repeat_time};
            default:           prdata = 32'd0;
        endcase
    end

    assign s_tready = !m_tvalid || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign tick     = in_fire && (s_tuser == MODE_TICK);
    assign div_inc  = div_reg + 8'd1;
    assign scan     = tick && (div_inc >= cfg_reg.scan_period);

    always_comb
    begin
        div_next = div_reg;
        if (tick)
        begin
            div_next = scan ? 8'd0 : div_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_period   <= 8'd20;
            cfg_reg.double_window <= 16'd200;
            cfg_reg.long_time     <= 16'd2000;
            cfg_reg.repeat_time   <= 16'd100;
            div_reg               <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            div_reg <= div_next;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        lane_ctrl_t ctrl;
        always_comb
        begin
            ctrl.tick  = tick;
            ctrl.scan  = scan;
            ctrl.clear = lane_clear[k];
            ctrl.mask  = event_mask;
            if (k < PIN_BITS)
            begin
                ctrl.pressed = !pin_levels[k];
            end
            else
            begin
                ctrl.pressed = 1'b0;
            end
        end
        mkcd_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cfg   (cfg_reg),
            .ctrl  (ctrl),
            .flags (lane_flags[k])
        );
    end

    mkcd_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_mode    (s_tuser),
        .key_index  (key_index),
        .event_mask (event_mask),
        .lane_flags (lane_flags),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_hit    (out_hit),
        .out_flags  (out_flags),
        .lane_clear (lane_clear)
    );

    assign m_tdata = {out_flags, out_hit};

    a_tick_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> (m_tvalid && m_tdata == 8'd0))
        else $error("tick item produced a nonzero result");

    a_bad_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == MODE_CHECK && int'(key_index) >= NUM_KEYS)
        |-> (lane_clear == '0) ##1 (m_tdata == 8'd0))
        else $error("check of a missing key touched state or reported flags");

    a_one_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lane_clear) && (lane_clear == '0 || in_fire))
        else $error("flag clear on more than one key or without an item");

endmodule

[hdl/mkcd_lane.sv]
// ----------------------------------------------------------------------------
// mkcd_lane
// one key: window timer, press level, click machine and sticky event flags
// ----------------------------------------------------------------------------
module mkcd_lane
    import mkcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  lane_ctrl_t ctrl,
    output ev_flags_t  flags
);

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_WAIT_LONG   = 3'd1,
        PH_WAIT_SECOND = 3'd2,
        PH_DOUBLE      = 3'd3,
        PH_LONG        = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic        cur_reg, cur_next;
    ev_flags_t   flags_reg, flags_next;
    logic [15:0] timer_dec;

    always_comb
    begin
        timer_dec  = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;
        phase_next = phase_reg;
        timer_next = timer_reg;
        cur_next   = cur_reg;
        flags_next = flags_reg;
        if (ctrl.clear)
        begin
            flags_next = flags_reg & ~ctrl.mask;
        end
        if (ctrl.tick)
        begin
            timer_next = timer_dec;
        end
        if (ctrl.scan)
        begin
            cur_next = ctrl.pressed;
            if (ctrl.pressed)
            begin
                flags_next = flags_next | EV_HOLD;
            end
            else
            begin
                flags_next = flags_next & ~EV_HOLD;
            end
            if (ctrl.pressed && !cur_reg)
            begin
                flags_next = flags_next | EV_DOWN;
            end
            if (!ctrl.pressed && cur_reg)
            begin
                flags_next = flags_next | EV_UP;
            end
            case (phase_reg)
                PH_WAIT_LONG:
                begin
                    if (!ctrl.pressed)
                    begin
                        timer_next = cfg.double_window;
                        phase_next = PH_WAIT_SECOND;
                    end
                    else if (timer_dec == 16'd0)
                    begin
                        timer_next = cfg.repeat_time;
                        flags_next = flags_next | EV_LONG;
                        phase_next = PH_LONG;
                    end
                end
                PH_WAIT_SECOND:
                begin
                    if (ctrl.pressed)
                    begin
                        flags_next = flags_next | EV_DOUBLE;
                        phase_next = PH_DOUBLE;
                    end
                    else if (timer_dec == 16'd0)
                    begin
                        flags_next = flags_next | EV_SINGLE;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DOUBLE:
                begin
                    if (!ctrl.pressed)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LONG:
                begin
                    if (!ctrl.pressed)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (timer_dec == 16'd0)
                    begin
                        timer_next = cfg.repeat_time;
                        flags_next = flags_next | EV_REPEAT;
                    end
                end
                default:
                begin
                    if (ctrl.pressed)
                    begin
                        timer_next = cfg.long_time;
                        phase_next = PH_WAIT_LONG;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= 16'd0;
            cur_reg   <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            cur_reg   <= cur_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

[hdl/mkcd_merge.sv]
// ----------------------------------------------------------------------------
// mkcd_merge
// picks the addressed key's flags, forms the hit and holds the result item
// ----------------------------------------------------------------------------
module mkcd_merge
    import mkcd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic                           in_mode,
    input  logic [KIDX_W-1:0]              key_index,
    input  ev_flags_t                      event_mask,
    input  logic [NUM_KEYS-1:0][EV_BITS-1:0] lane_flags,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           out_hit,
    output ev_flags_t                      out_flags,
    output logic [NUM_KEYS-1:0]            lane_clear
);

    logic      valid_reg, valid_next;
    logic      hit_reg, hit_next;
    ev_flags_t seen_reg, seen_next;
    ev_flags_t seen;
    logic [NUM_KEYS-1:0] sel;
    logic      hit;

    always_comb
    begin
        seen = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            sel[k] = (in_mode == MODE_CHECK) && (int'(key_index) == k);
            if (sel[k])
            begin
                seen = seen | lane_flags[k];
            end
        end
        hit = |(seen & event_mask);
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            lane_clear[k] = in_fire && sel[k] && hit && (event_mask != EV_HOLD);
        end
        valid_next = in_fire ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        hit_next   = in_fire ? hit  : hit_reg;
        seen_next  = in_fire ? seen : seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        seen_reg <= seen_next;
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;
    assign out_flags = seen_reg;

endmodule

[dv/mkcd_click_checker.sv]
// ----------------------------------------------------------------------------
// mkcd_click_checker
// watches the register port and both item streams of the click event
// detector, predicts every result item from its own model of the key lanes
// and compares each delivered result field by field, oldest first
// ----------------------------------------------------------------------------
module mkcd_click_checker
    import mkcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // pin_levels[4:0], key_index[7:5], event_mask[14:8], 0
    input  logic        s_tuser,   // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // hit[0], flags_seen[7:1]
    output int          pending_results,
    output int          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        CLK_IDLE,
        CLK_WAIT_LONG,
        CLK_WAIT_SECOND,
        CLK_DOUBLE_HELD,
        CLK_LONG_HELD
    } click_phase_e;

    typedef struct packed {
        ev_flags_t flags;
        logic      hit;
    } click_result_t;

    cfg_t            cfg;
    logic [7:0]      scan_div;
    logic            now_pressed  [NUM_KEYS];
    logic            was_pressed  [NUM_KEYS];
    click_phase_e    key_phase    [NUM_KEYS];
    logic [15:0]     key_timer    [NUM_KEYS];
    ev_flags_t       key_flags    [NUM_KEYS];
    click_result_t   expected_results [$];

    initial mismatch_count = 0;
    initial pending_results = 0;

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void sample_key(int k, logic pressed);
        ev_flags_t f;
        f = key_flags[k];
        was_pressed[k] = now_pressed[k];
        now_pressed[k] = pressed;
        if (pressed)
            f = f | EV_HOLD;
        else
            f = f & ~EV_HOLD;
        if (pressed && !was_pressed[k])
            f = f | EV_DOWN;
        if (!pressed && was_pressed[k])
            f = f | EV_UP;
        case (key_phase[k])
            CLK_WAIT_LONG:
            begin
                if (!pressed)
                begin
                    key_timer[k] = cfg.double_window;
                    key_phase[k] = CLK_WAIT_SECOND;
                end
                else if (key_timer[k] == 16'd0)
                begin
                    key_timer[k] = cfg.repeat_time;
                    f = f | EV_LONG;
                    key_phase[k] = CLK_LONG_HELD;
                end
            end
            CLK_WAIT_SECOND:
            begin
                if (pressed)
                begin
                    f = f | EV_DOUBLE;
                    key_phase[k] = CLK_DOUBLE_HELD;
                end
                else if (key_timer[k] == 16'd0)
                begin
                    f = f | EV_SINGLE;
                    key_phase[k] = CLK_IDLE;
                end
            end
            CLK_DOUBLE_HELD:
            begin
                if (!pressed)
                    key_phase[k] = CLK_IDLE;
            end
            CLK_LONG_HELD:
            begin
                if (!pressed)
                    key_phase[k] = CLK_IDLE;
                else if (key_timer[k] == 16'd0)
                begin
                    key_timer[k] = cfg.repeat_time;
                    f = f | EV_REPEAT;
                end
            end
            default:
            begin
                if (pressed)
                begin
                    key_timer[k] = cfg.long_time;
                    key_phase[k] = CLK_WAIT_LONG;
                end
                else
                    key_phase[k] = CLK_IDLE;
            end
        endcase
        key_flags[k] = f;
    endfunction

    function automatic click_result_t apply_item(logic mode, logic [4:0] pins,
                                                 logic [2:0] key, ev_flags_t mask);
        click_result_t r;
        ev_flags_t     seen;
        r = '0;
        if (mode == MODE_CHECK)
        begin
            if (key < NUM_KEYS)
            begin
                seen = key_flags[key];
                r.flags = seen;
                if ((seen & mask) != '0)
                begin
                    r.hit = 1'b1;
                    if (mask != EV_HOLD)
                        key_flags[key] = seen & ~mask;
                end
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                if (key_timer[k] != 16'd0)
                    key_timer[k] = key_timer[k] - 16'd1;
            scan_div = scan_div + 8'd1;
            if (scan_div >= cfg.scan_period)
            begin
                scan_div = 8'd0;
                for (int k = 0; k < NUM_KEYS; k++)
                    sample_key(k, (k < PIN_BITS) ? ~pins[k] : 1'b0);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        click_result_t got;
        click_result_t want;
        if (!rst_n)
        begin
            cfg.scan_period   = 8'd20;
            cfg.double_window = 16'd200;
            cfg.long_time     = 16'd2000;
            cfg.repeat_time   = 16'd100;
            scan_div = 8'd0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                now_pressed[k] = 1'b0;
                was_pressed[k] = 1'b0;
                key_phase[k]   = CLK_IDLE;
                key_timer[k]   = 16'd0;
                key_flags[k]   = '0;
            end
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SCAN_PERIOD:   cfg.scan_period   = pwdata[7:0];
                    REG_DOUBLE_WINDOW: cfg.double_window = pwdata[15:0];
                    REG_LONG_TIME:     cfg.long_time     = pwdata[15:0];
                    REG_REPEAT_TIME:   cfg.repeat_time   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_item(s_tuser, s_tdata[4:0],
                                                      s_tdata[7:5], s_tdata[14:8]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %02h", m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
                    if (got.flags !== want.flags)
                        report_mismatch($sformatf("flags_seen %02h, want %02h",
                                                  got.flags, want.flags));
                end
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

[dv/multi_key_click_event_detector_test.sv]
// ----------------------------------------------------------------------------
// multi_key_click_event_detector_test
// drives key tick and check items through the detector under several register
// settings, with random gaps on both streams outside one steady phase; the
// checker predicts and compares every result item
// ----------------------------------------------------------------------------
module multi_key_click_event_detector_test
    import mkcd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // pin_levels[4:0], key_index[7:5], event_mask[14:8], 0
    logic        s_tuser  = 1'b0; // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // hit[0], flags_seen[7:1]

    int          pending_results;
    int          mismatch_count;
    bit          steady = 1'b0;
    logic [4:0]  pin_state = 5'h1f;
    int          run_left [NUM_KEYS];
    int          sp_cur;
    int          dw_cur;
    int          lt_cur;
    int          rt_cur;

    multi_key_click_event_detector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mkcd_click_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 19);

    task automatic send_item(logic mode, logic [4:0] pins, logic [2:0] key, ev_flags_t mask);
        if (!steady)
            while ($urandom_range(0, 99) < 19)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, mask, key, pins};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic tick(logic [4:0] pins);
        send_item(MODE_TICK, pins, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
    endtask

    task automatic check(logic [2:0] key, ev_flags_t mask);
        send_item(MODE_CHECK, 5'($urandom_range(0, 31)), key, mask);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timing(int sp, int dw, int lt, int rt);
        wait_idle();
        write_reg(REG_SCAN_PERIOD, sp);
        write_reg(REG_DOUBLE_WINDOW, dw);
        write_reg(REG_LONG_TIME, lt);
        write_reg(REG_REPEAT_TIME, rt);
        sp_cur = sp;
        dw_cur = dw;
        lt_cur = lt;
        rt_cur = rt;
    endtask

    function automatic int pick_run();
        int span;
        span = lt_cur + 2 * rt_cur + 4 * (sp_cur + 1);
        if (span > 200)
            span = 200;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, span);
        span = 2 * (sp_cur + 1) + ((dw_cur > 100) ? 100 : dw_cur);
        return $urandom_range(1, span);
    endfunction

    task automatic run_phase(int count, bit pause_midway);
        int        r;
        logic [2:0] key;
        ev_flags_t mask;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_idle();
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                if ($urandom_range(0, 9) == 0)
                    key = 3'($urandom_range(NUM_KEYS, 7));
                else
                    key = 3'($urandom_range(0, NUM_KEYS - 1));
                case ($urandom_range(0, 5))
                    0:       mask = '1;
                    1:       mask = EV_HOLD;
                    2:       mask = '0;
                    3:       mask = 7'($urandom_range(0, 127));
                    default: mask = ev_flags_t'(1) << $urandom_range(0, 6);
                endcase
                check(key, mask);
            end
            else if (r < 30)
                tick(5'($urandom_range(0, 31)));
            else
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (run_left[k] <= 0)
                    begin
                        pin_state[k] = ~pin_state[k];
                        run_left[k] = pick_run();
                    end
                    else
                        run_left[k]--;
                end
                tick(pin_state);
            end
        end
    endtask

    initial
    begin
        int sp;
        int dw;
        int lt;
        int rt;
        for (int k = 0; k < NUM_KEYS; k++)
            run_left[k] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: flags empty, out of range key
        check(3'd0, '1);
        check(3'd7, '1);
        tick(5'h1f);

        // zero windows, every tick samples
        set_timing(0, 0, 0, 0);
        tick(5'b11100);
        tick(5'b11110);
        tick(5'b11100);
        check(3'd0, EV_HOLD);
        tick(5'b11111);
        check(3'd0, '1);
        check(3'd1, EV_DOUBLE | EV_UP);
        check(3'd1, '0);
        check(3'd5, '1);
        check(3'd6, EV_DOWN);
        tick(5'b01111);
        tick(5'b11111);
        tick(5'b11111);
        check(3'd4, EV_SINGLE);
        check(3'd4, '1);
        check(3'd2, '1);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    sp = 1; dw = 0; lt = 0; rt = 0;
                end
                1:
                begin
                    sp = 255; dw = 16'hffff; lt = 16'hffff; rt = 16'hffff;
                end
                2:
                begin
                    sp = 0; dw = 5; lt = 12; rt = 3;
                end
                default:
                begin
                    sp = $urandom_range(0, 4);
                    dw = $urandom_range(0, 40);
                    lt = $urandom_range(0, 60);
                    rt = $urandom_range(0, 20);
                    if ($urandom_range(0, 5) == 0)
                        rt = 16'hffff;
                end
            endcase
            set_timing(sp, dw, lt, rt);
            steady = (p == 4);
            run_phase((p == 1) ? 100 : 215, p == 5);
        end
        steady = 1'b0;

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
